[src/psd_pkg.sv]
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants
// Field widths, result kind codes and the item records that move between
// the cells of the point-to-segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int COORD_W = 32;            // input coordinate width
   localparam int DIST_W  = 32;            // output distance width
   localparam int SQ_W    = 66;            // sum of three squared differences
   localparam int NUM_W   = 2 * DIST_W;    // quotient / radicand width
   localparam int N2_W    = 132;           // squared cross product norm
   localparam int DIV_STEPS  = NUM_W;      // one quotient bit per cell
   localparam int SQRT_STEPS = DIST_W;     // one root bit per cell

   typedef enum logic [1:0] {
      KIND_PERP  = 2'd0,
      KIND_START = 2'd1,
      KIND_END   = 2'd2,
      KIND_DEGEN = 2'd3
   } kind_type;

   // one item in the divider chain; num shifts out numerator bits and
   // shifts in quotient bits
   typedef struct packed {
      logic [SQ_W-1:0]  rem;
      logic [SQ_W-1:0]  den;
      logic [NUM_W-1:0] num;
      kind_type         kind;
      logic             sat;
   } div_type;

   // one item in the square root chain
   typedef struct packed {
      logic [NUM_W-1:0]  x;
      logic [DIST_W+1:0] rem;
      logic [DIST_W-1:0] root;
      kind_type          kind;
      logic              sat;
   } sqt_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      kind_type          kind;
      logic              sat;
   } rsp_type;

endpackage

[src/psd_front.sv]
// ----------------------------------------------------------------------------
// psd_front: squared lengths, projection test and cross product norm
// Eight register stages that turn one segment/point item into a
// numerator, divisor and case code for the divider chain.
// ----------------------------------------------------------------------------
module psd_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   valid_in,
   input  logic signed [psd_pkg::COORD_W-1:0]     s_in [3],
   input  logic signed [psd_pkg::COORD_W-1:0]     p_in [3],
   input  logic signed [psd_pkg::COORD_W-1:0]     e_in [3],
   output logic                                   valid_out,
   output psd_pkg::div_type                       item_out
);

   localparam int CW = psd_pkg::COORD_W;
   localparam int SW = psd_pkg::SQ_W;
   localparam int NW = psd_pkg::N2_W;

   logic [7:0] vld_ff;

   // stage 1: difference magnitudes and signs
   logic [CW-1:0] dm_ff [3], fm_ff [3], em_ff [3];
   logic [CW-1:0] dm_in [3], fm_in [3], em_in [3];
   logic [2:0]    dn_ff, en_ff, dn_in, en_in;

   // stage 2: products
   logic [2*CW-1:0] sa_ff [3], sb_ff [3], sc_ff [3], dt_ff [3], u_ff [3], v_ff [3];
   logic [2*CW-1:0] sa_in [3], sb_in [3], sc_in [3], dt_in [3], u_in [3], v_in [3];
   logic [2:0]      dts_ff, us_ff, vs_ff, dts_in, us_in, vs_in;

   // stage 3: sums
   logic [SW-1:0]        a2_ff, b2_ff, c2_ff, a2_in, b2_in, c2_in;
   logic signed [SW:0]   dot_ff, dot_in;
   logic signed [SW-1:0] cr_ff [3], cr_in [3];

   // stage 4: case decision and cross magnitudes
   logic [SW-2:0]  ca_ff [3], ca_in [3];
   logic [SW-1:0]  ep4_ff, c24_ff, ep4_in;
   psd_pkg::kind_type k4_ff, k4_in;

   // stage 5: partial squares
   logic [65:0] phh_ff [3], phh_in [3];
   logic [64:0] phl_ff [3], phl_in [3];
   logic [63:0] pll_ff [3], pll_in [3];
   logic [SW-1:0] ep5_ff, c25_ff;
   psd_pkg::kind_type k5_ff;

   // stage 6: component squares
   logic [129:0] cs_ff [3], cs_in [3];
   logic [SW-1:0] ep6_ff, c26_ff;
   psd_pkg::kind_type k6_ff;

   // stage 7: numerator
   logic [NW-1:0] n2_ff, n2_in;
   logic [SW-1:0] ep7_ff, c27_ff;
   psd_pkg::kind_type k7_ff;

   // stage 8: divider input
   psd_pkg::div_type d8_ff, d8_in;
   logic [NW-1:0] nsel;
   logic [SW-1:0] dsel;

   localparam int IA [3] = '{1, 2, 0};
   localparam int IB [3] = '{2, 0, 1};

   always_comb begin
      logic [CW:0] ds, df, de;
      logic signed [SW-1:0] su, sv;
      logic signed [SW:0]   acc;
      acc = '0;
      for (int k = 0; k < 3; k++) begin
         ds = {p_in[k][CW-1], p_in[k]} - {s_in[k][CW-1], s_in[k]};
         df = {e_in[k][CW-1], e_in[k]} - {p_in[k][CW-1], p_in[k]};
         de = {e_in[k][CW-1], e_in[k]} - {s_in[k][CW-1], s_in[k]};
         dn_in[k] = ds[CW];
         en_in[k] = de[CW];
         dm_in[k] = ds[CW] ? CW'(-ds) : ds[CW-1:0];
         fm_in[k] = df[CW] ? CW'(-df) : df[CW-1:0];
         em_in[k] = de[CW] ? CW'(-de) : de[CW-1:0];
      end
      // products of magnitudes, one multiplier each
      for (int k = 0; k < 3; k++) begin
         sa_in[k]  = dm_ff[k] * dm_ff[k];
         sb_in[k]  = fm_ff[k] * fm_ff[k];
         sc_in[k]  = em_ff[k] * em_ff[k];
         dt_in[k]  = dm_ff[k] * em_ff[k];
         dts_in[k] = dn_ff[k] ^ en_ff[k];
         u_in[k]   = dm_ff[IA[k]] * em_ff[IB[k]];
         us_in[k]  = dn_ff[IA[k]] ^ en_ff[IB[k]];
         v_in[k]   = dm_ff[IB[k]] * em_ff[IA[k]];
         vs_in[k]  = dn_ff[IB[k]] ^ en_ff[IA[k]];
      end
      // sums of squares, signed dot product, signed cross components
      a2_in = {2'b0, sa_ff[0]} + {2'b0, sa_ff[1]} + {2'b0, sa_ff[2]};
      b2_in = {2'b0, sb_ff[0]} + {2'b0, sb_ff[1]} + {2'b0, sb_ff[2]};
      c2_in = {2'b0, sc_ff[0]} + {2'b0, sc_ff[1]} + {2'b0, sc_ff[2]};
      for (int k = 0; k < 3; k++) begin
         if (dts_ff[k]) acc = acc - $signed({3'b0, dt_ff[k]});
         else           acc = acc + $signed({3'b0, dt_ff[k]});
         su = $signed({2'b0, u_ff[k]});
         sv = $signed({2'b0, v_ff[k]});
         cr_in[k] = (us_ff[k] ? -su : su) - (vs_ff[k] ? -sv : sv);
      end
      dot_in = acc;
      // decide the case; projection on an endpoint counts as inside
      for (int k = 0; k < 3; k++) begin
         ca_in[k] = cr_ff[k][SW-1] ? (SW-1)'(-cr_ff[k]) : cr_ff[k][SW-2:0];
      end
      if (c2_ff == '0) begin
         k4_in  = psd_pkg::KIND_DEGEN;
         ep4_in = b2_ff;
      end else if (dot_ff < 0 || dot_ff > $signed({1'b0, c2_ff})) begin
         if (a2_ff < b2_ff) begin
            k4_in  = psd_pkg::KIND_START;
            ep4_in = a2_ff;
         end else begin
            k4_in  = psd_pkg::KIND_END;
            ep4_in = b2_ff;
         end
      end else begin
         k4_in  = psd_pkg::KIND_PERP;
         ep4_in = b2_ff;
      end
      // split each cross magnitude into 33 + 32 bit halves
      for (int k = 0; k < 3; k++) begin
         phh_in[k] = ca_ff[k][64:32] * ca_ff[k][64:32];
         phl_in[k] = ca_ff[k][64:32] * ca_ff[k][31:0];
         pll_in[k] = ca_ff[k][31:0] * ca_ff[k][31:0];
         cs_in[k]  = {phh_ff[k], 64'h0} + {32'h0, phl_ff[k], 33'h0} + {66'h0, pll_ff[k]};
      end
      n2_in = {2'b0, cs_ff[0]} + {2'b0, cs_ff[1]} + {2'b0, cs_ff[2]};
      // endpoint and degenerate cases divide by one
      if (k7_ff == psd_pkg::KIND_PERP) begin
         nsel = n2_ff;
         dsel = c27_ff;
      end else begin
         nsel = {{(NW-SW){1'b0}}, ep7_ff};
         dsel = SW'(1);
      end
      d8_in.rem  = nsel[NW-3:psd_pkg::NUM_W];
      d8_in.num  = nsel[psd_pkg::NUM_W-1:0];
      d8_in.den  = dsel;
      d8_in.kind = k7_ff;
      d8_in.sat  = nsel[NW-1:psd_pkg::NUM_W] >= {2'b0, dsel};
   end

   // advance all stages together
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[6:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dm_ff <= dm_in;  fm_ff <= fm_in;  em_ff <= em_in;
         dn_ff <= dn_in;  en_ff <= en_in;
         sa_ff <= sa_in;  sb_ff <= sb_in;  sc_ff <= sc_in;
         dt_ff <= dt_in;  u_ff  <= u_in;   v_ff  <= v_in;
         dts_ff <= dts_in; us_ff <= us_in; vs_ff <= vs_in;
         a2_ff <= a2_in;  b2_ff <= b2_in;  c2_ff <= c2_in;
         dot_ff <= dot_in; cr_ff <= cr_in;
         ca_ff <= ca_in;  ep4_ff <= ep4_in; c24_ff <= c2_ff; k4_ff <= k4_in;
         phh_ff <= phh_in; phl_ff <= phl_in; pll_ff <= pll_in;
         ep5_ff <= ep4_ff; c25_ff <= c24_ff; k5_ff <= k4_ff;
         cs_ff <= cs_in;  ep6_ff <= ep5_ff; c26_ff <= c25_ff; k6_ff <= k5_ff;
         n2_ff <= n2_in;  ep7_ff <= ep6_ff; c27_ff <= c26_ff; k7_ff <= k6_ff;
         d8_ff <= d8_in;
      end
   end

   assign valid_out = vld_ff[7];
   assign item_out  = d8_ff;

endmodule

[src/psd_div_cell.sv]
// ----------------------------------------------------------------------------
// psd_div_cell: one restoring division step
// Shifts one numerator bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit into the item.
// ----------------------------------------------------------------------------
module psd_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             valid_in,
   input  psd_pkg::div_type item_in,
   output logic             valid_out,
   output psd_pkg::div_type item_out
);

   localparam int SW = psd_pkg::SQ_W;
   localparam int NW = psd_pkg::NUM_W;

   logic             valid_ff;
   psd_pkg::div_type item_ff, item_in_c;
   logic [SW:0]      trial, diff;
   logic             fits;

   // compare and subtract
   always_comb begin
      trial = {item_in.rem, item_in.num[NW-1]};
      diff  = trial - {1'b0, item_in.den};
      fits  = trial >= {1'b0, item_in.den};
      item_in_c      = item_in;
      item_in_c.rem  = fits ? diff[SW-1:0] : trial[SW-1:0];
      item_in_c.num  = {item_in.num[NW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign item_out  = item_ff;

endmodule

[src/psd_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// psd_sqrt_cell: one digit-by-digit square root step
// Brings down two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module psd_sqrt_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             valid_in,
   input  psd_pkg::sqt_type item_in,
   output logic             valid_out,
   output psd_pkg::sqt_type item_out
);

   localparam int DW = psd_pkg::DIST_W;
   localparam int NW = psd_pkg::NUM_W;

   logic             valid_ff;
   psd_pkg::sqt_type item_ff, item_in_c;
   logic [DW+3:0]    acc, trial, diff;
   logic             fits;

   // trial subtract of 4*root + 1
   always_comb begin
      acc   = {item_in.rem, item_in.x[NW-1:NW-2]};
      trial = {2'b0, item_in.root, 2'b01};
      diff  = acc - trial;
      fits  = acc >= trial;
      item_in_c      = item_in;
      item_in_c.rem  = fits ? diff[DW+1:0] : acc[DW+1:0];
      item_in_c.root = {item_in.root[DW-2:0], fits};
      item_in_c.x    = {item_in.x[NW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign item_out  = item_ff;

endmodule

[src/point_segment_distance_3d_top.sv]
// ----------------------------------------------------------------------------
// point_segment_distance_3d_top: 3D point to segment distance
// Streaming distance from a query point to a segment, signed Q16.16 in,
// unsigned Q16.16 out, built as a front end and two chains of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one query: start, point and end coordinates in tdata.
//   rsp_*  carries one result per query, in order: distance in tdata,
//          nearest kind and the saturation flag in tuser.
//   One item is accepted per cycle while req_tready is high. Between
//   acceptance and rsp_tvalid lie 8 front end stages (squares, projection
//   test, cross product norm), 64 divider cells (one quotient bit each),
//   32 square root cells (one root bit each) and the output register.
//   The whole chain advances as one; an output register plus one skid
//   register let a new item enter while a result waits. When the receiver
//   stalls, the skid fills and req_tready drops until it drains.
//   Reset empties the chain and the output registers; no item is lost
//   or invented afterwards.
// ----------------------------------------------------------------------------
module point_segment_distance_3d_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_x, start_y, start_z, point_x, point_y, point_z, end_x, end_y, end_z
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // distance
   output logic [31:0]  rsp_tdata,
   // nearest_kind, saturated
   output logic [2:0]   rsp_tuser
);

   localparam int CW = psd_pkg::COORD_W;
   localparam int DS = psd_pkg::DIV_STEPS;
   localparam int QS = psd_pkg::SQRT_STEPS;

   logic en;
   logic signed [CW-1:0] s_c [3], p_c [3], e_c [3];

   // unpack coordinates
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s_c[k] = req_tdata[CW*k +: CW];
         p_c[k] = req_tdata[CW*(3+k) +: CW];
         e_c[k] = req_tdata[CW*(6+k) +: CW];
      end
   end

   logic             dv [DS+1];
   psd_pkg::div_type di [DS+1];

   psd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (req_tvalid & req_tready),
      .s_in      (s_c),
      .p_in      (p_c),
      .e_in      (e_c),
      .valid_out (dv[0]),
      .item_out  (di[0])
   );

   for (genvar g = 0; g < DS; g++) begin : g_div
      psd_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .valid_in  (dv[g]),
         .item_in   (di[g]),
         .valid_out (dv[g+1]),
         .item_out  (di[g+1])
      );
   end

   logic             qv [QS+1];
   psd_pkg::sqt_type qi [QS+1];

   // hand the quotient to the root chain
   always_comb begin
      qv[0]      = dv[DS];
      qi[0].x    = di[DS].num;
      qi[0].rem  = '0;
      qi[0].root = '0;
      qi[0].kind = di[DS].kind;
      qi[0].sat  = di[DS].sat;
   end

   for (genvar g = 0; g < QS; g++) begin : g_sqrt
      psd_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .valid_in  (qv[g]),
         .item_in   (qi[g]),
         .valid_out (qv[g+1]),
         .item_out  (qi[g+1])
      );
   end

   // output register and skid
   psd_pkg::rsp_type pipe_c, out_ff, out_in, skid_ff, skid_in;
   logic out_v_ff, out_v_in, skid_v_ff, skid_v_in, pipe_v, take;

   assign en     = ~skid_v_ff;
   assign take   = out_v_ff & rsp_tready;
   assign pipe_v = en & qv[QS];

   always_comb begin
      pipe_c.distance = qi[QS].sat ? '1 : qi[QS].root;
      pipe_c.kind     = qi[QS].kind;
      pipe_c.sat      = qi[QS].sat;
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (!out_v_ff || take) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_in    = skid_ff;
            skid_v_in = 1'b0;
         end else begin
            out_v_in = pipe_v;
            out_in   = pipe_c;
         end
      end else if (pipe_v) begin
         skid_v_in = 1'b1;
         skid_in   = pipe_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_tready = en;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff.distance;
   assign rsp_tuser  = {out_ff.sat, out_ff.kind};

`ifndef NO_ASSERTIONS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid holds an item while output register is empty");

   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> !req_tready)
      else $error("input accepted while skid is full");

   a_sat_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |-> (rsp_tdata == 32'hFFFF_FFFF))
      else $error("saturated result without full scale distance");
`endif

endmodule

[sim/point_segment_distance_3d_checker.sv]
// ----------------------------------------------------------------------------
// point_segment_distance_3d_checker: result predictor and scoreboard
// Watches both streams of the distance block. Each query taken in yields
// one predicted distance, kind and saturation flag. Each result that
// leaves the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module point_segment_distance_3d_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // start_x, start_y, start_z, point_x, point_y, point_z, end_x, end_y, end_z
   input  logic [287:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // distance
   input  logic [31:0]  rsp_tdata,
   // nearest_kind, saturated
   input  logic [2:0]   rsp_tuser,
   output int           fail_count,
   output int           pending_count
);

   typedef logic signed [255:0] wide_type;

   psd_pkg::rsp_type pending_results[$];

   // truncating square root of a wide radicand, 64 root bits
   function automatic logic [63:0] floor_sqrt(logic [255:0] x);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [255:0] sq;
      r = '0;
      for (int k = 63; k >= 0; k--) begin
         c  = r | (64'd1 << k);
         sq = {192'd0, c} * {192'd0, c};
         if (sq <= x) r = c;
      end
      return r;
   endfunction

   // exact distance from the query point to the closed segment
   function automatic psd_pkg::rsp_type segment_distance(logic [287:0] q);
      wide_type s[3], p[3], e[3], d[3], f[3], g[3];
      wide_type a2, b2, c2, dot, cx, cy, cz, n2;
      logic [63:0] root;
      psd_pkg::rsp_type r;
      for (int k = 0; k < 3; k++) begin
         s[k] = wide_type'(signed'(q[k*32 +: 32]));
         p[k] = wide_type'(signed'(q[(3+k)*32 +: 32]));
         e[k] = wide_type'(signed'(q[(6+k)*32 +: 32]));
         d[k] = p[k] - s[k];
         f[k] = e[k] - p[k];
         g[k] = e[k] - s[k];
      end
      a2  = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
      b2  = f[0]*f[0] + f[1]*f[1] + f[2]*f[2];
      c2  = g[0]*g[0] + g[1]*g[1] + g[2]*g[2];
      dot = d[0]*g[0] + d[1]*g[1] + d[2]*g[2];
      if (c2 == 0) begin
         root   = floor_sqrt(b2);
         r.kind = psd_pkg::KIND_DEGEN;
      end else if (dot < 0 || dot > c2) begin
         // outside: nearer endpoint, ties go to the end
         if (a2 < b2) begin
            root   = floor_sqrt(a2);
            r.kind = psd_pkg::KIND_START;
         end else begin
            root   = floor_sqrt(b2);
            r.kind = psd_pkg::KIND_END;
         end
      end else begin
         cx     = d[1]*g[2] - d[2]*g[1];
         cy     = d[2]*g[0] - d[0]*g[2];
         cz     = d[0]*g[1] - d[1]*g[0];
         n2     = cx*cx + cy*cy + cz*cz;
         root   = floor_sqrt(256'(n2) / 256'(c2));
         r.kind = psd_pkg::KIND_PERP;
      end
      if (root > 64'hFFFF_FFFF) begin
         r.distance = '1;
         r.sat      = 1'b1;
      end else begin
         r.distance = root[31:0];
         r.sat      = 1'b0;
      end
      return r;
   endfunction

   // predict on every query taken, compare on every result taken
   always @(posedge clock) begin
      psd_pkg::rsp_type want;
      int errs;
      errs = 0;
      if (reset) begin
         pending_results.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            pending_results.push_back(segment_distance(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result: distance %h tuser %b", rsp_tdata, rsp_tuser);
               errs++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata !== want.distance) begin
                  $error("distance: expected %h actual %h", want.distance, rsp_tdata);
                  errs++;
               end
               if (rsp_tuser[1:0] !== want.kind) begin
                  $error("nearest_kind: expected %0d actual %0d", want.kind, rsp_tuser[1:0]);
                  errs++;
               end
               if (rsp_tuser[2] !== want.sat) begin
                  $error("saturated: expected %b actual %b", want.sat, rsp_tuser[2]);
                  errs++;
               end
            end
         end
         fail_count    <= fail_count + errs;
         pending_count <= pending_results.size();
      end
   end

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: stream test of the point-to-segment distance block
// Sends directed corner queries, then random ones in bursts with gaps,
// while the result side stalls on its own pattern. The checker predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

   localparam int RANDOM_QUERIES = 1750;
   localparam int IDLE_LIMIT     = 5000;
   localparam int DRAIN_CYCLES   = 150;

   localparam logic [31:0] C_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] C_MIN  = 32'h8000_0000;
   localparam logic [31:0] C_ZERO = 32'h0000_0000;
   localparam logic [31:0] C_ONE  = 32'h0001_0000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [287:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   int           fail_count;
   int           pending_count;
   int           idle_cycles;

   point_segment_distance_3d_top dut (.*);

   point_segment_distance_3d_checker checker_i (.*);

   // clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // stall the result side, switching between modes now and then
   initial begin
      int mode;
      int span;
      rsp_tready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(30, 250);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0: rsp_tready = 1'b1;
               1: rsp_tready = $urandom_range(0, 1);
               2: rsp_tready = ($urandom_range(0, 7) != 0);
               default: rsp_tready = ($urandom_range(0, 9) == 0);
            endcase
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   int burst_left;

   // hold one query until it is taken, then maybe open a gap
   task automatic send_query(logic [31:0] sx, sy, sz, px, py, pz, ex, ey, ez);
      req_tdata  = {ez, ey, ex, pz, py, px, sz, sy, sx};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
         burst_left = $urandom_range(0, 40);
      end
   endtask

   // one coordinate: full range, a band around a base, or a band around zero
   function automatic logic [31:0] pick_coord(int mode, logic [31:0] base);
      case (mode)
         0: return $urandom;
         1: return base + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         2: return base + $urandom_range(0, 32'h0000_0010) - 32'h0000_0008;
         default: return signed'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      endcase
   endfunction

   initial begin
      logic [31:0] b[3];
      logic [31:0] c[9];
      int mode;
      burst_left  = 0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      reset       = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all zero: degenerate
      send_query('0, '0, '0, '0, '0, '0, '0, '0, '0);
      // degenerate segment, far point: saturates
      send_query(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
      // longest segment, point in the middle on the line
      send_query(C_MIN, C_MIN, C_MIN, '0, '0, '0, C_MAX, C_MAX, C_MAX);
      // longest segment, point far off the line
      send_query(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX);
      // perpendicular unit distance
      send_query('0, '0, '0, C_ONE, C_ONE, '0, 2 * C_ONE, '0, '0);
      // projection exactly on the start and on the end
      send_query('0, '0, '0, '0, C_ONE, '0, C_ONE, '0, '0);
      send_query('0, '0, '0, C_ONE, C_ONE, '0, C_ONE, '0, '0);
      // point coincident with an endpoint
      send_query(C_ONE, C_ONE, C_ONE, C_ONE, C_ONE, C_ONE, '0, '0, '0);
      // outside before the start and beyond the end
      send_query('0, '0, '0, -C_ONE, C_ONE, '0, C_ONE, '0, '0);
      send_query('0, '0, '0, 3 * C_ONE, C_ONE, '0, C_ONE, '0, '0);
      // outside beyond the end, far: endpoint distance saturates
      send_query(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX - 1);
      // outside with extreme coordinates mixed
      send_query(C_MAX, C_MIN, C_ZERO, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX);
      // one raw unit segment, point one raw unit away
      send_query('0, '0, '0, '0, 32'd1, '0, 32'd1, '0, '0);
      send_query(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);

      // random queries, mostly near-by geometry
      repeat (RANDOM_QUERIES) begin
         mode = $urandom_range(0, 9);
         b[0] = $urandom; b[1] = $urandom; b[2] = $urandom;
         for (int k = 0; k < 9; k++)
            c[k] = (mode < 2) ? pick_coord(0, '0) :
                   (mode < 5) ? pick_coord(1, b[k % 3]) :
                   (mode < 7) ? pick_coord(2, b[k % 3]) : pick_coord(3, '0);
         // sometimes collapse the segment
         if ($urandom_range(0, 15) == 0) begin
            c[6] = c[0]; c[7] = c[1]; c[8] = c[2];
         end
         send_query(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]);
      end
      req_tvalid = 1'b0;

      // drain, then let the pipeline settle
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
